// ----- hdl/byte_ring_with_atomic_commit_defines.svh -----
// Assertion macros shared by the checker of the byte ring.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BYTE_RING_WITH_ATOMIC_COMMIT_DEFINES_SVH
`define BYTE_RING_WITH_ATOMIC_COMMIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BRAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BRAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/brac_pkg.sv -----
// Package of the byte ring: widths, codes, queue depths and item structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package brac_pkg;

  localparam int RING_DEPTH_DEF   = 1024;
  localparam int MAX_READ_RUN_DEF = 64;
  localparam int CQ_DEPTH         = 2;
  localparam int OQ_DEPTH         = 4;

  localparam int LEN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int RUN_W  = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_DONE  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic              legal;
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [RUN_W-1:0]  run_max;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic              status;
    logic [BYTE_W-1:0] rbyte;
    logic              last;
    logic [LEN_W-1:0]  held;
    logic              done;
  } res_t;

endpackage

// ----- hdl/byte_ring_with_atomic_commit.sv -----
// Top level of the byte ring with whole-payload admission.
// Depends on brac_pkg, brac_front, brac_back and brac_out_q.
//
// A write or done item is handled by the back end in the cycle it is taken; a
// read item drains its bytes one at a time through the single read port of the
// ring store, and no other item is taken until the run ends. A payload byte
// can be taken every cycle while no read run is in progress and the result
// queue has room, and a read of n bytes streams n results back to back unless
// the result queue fills. An accepted item passes through the command queue,
// then the result stage that also reads the ring store, after which it waits
// in the result queue. The back end holds while the result queue has no room,
// and the input goes full once the command queue holds two items. The ring
// store is not cleared after reset; only bytes of admitted payloads are ever
// drained. Write the capacity only while no results are outstanding; a write of zero is ignored.
`timescale 1ns / 1ps

module byte_ring_with_atomic_commit import brac_pkg::*; #(
  parameter int RING_DEPTH   = RING_DEPTH_DEF,
  parameter int MAX_READ_RUN = MAX_READ_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_first_of_payload,
  input  logic              in_last_of_payload,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [RUN_W-1:0]  in_max_count,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_kind,
  output logic              out_status,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_last_of_run,
  output logic [LEN_W-1:0]  out_bytes_held,
  output logic              out_done_flag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic oq_room;
  res_t res;
  logic res_valid;
  res_t head;

  assign cfg_ready = 1'b1;

  brac_front #(
    .MAX_READ_RUN (MAX_READ_RUN)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .in_first_of_payload (in_first_of_payload),
    .in_last_of_payload  (in_last_of_payload),
    .in_payload_length   (in_payload_length),
    .in_max_count        (in_max_count),
    .cmd                 (cmd),
    .cmd_valid           (cmd_valid),
    .cmd_take            (cmd_take)
  );

  brac_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .oq_room   (oq_room),
    .res       (res),
    .res_valid (res_valid)
  );

  brac_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .room  (oq_room),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (head)
  );

  assign out_kind        = head.kind;
  assign out_status      = head.status;
  assign out_read_byte   = head.rbyte;
  assign out_last_of_run = head.last;
  assign out_bytes_held  = head.held;
  assign out_done_flag   = head.done;

endmodule

// ----- hdl/brac_front.sv -----
// Front end of the byte ring: accepts input items, decodes them into commands
// and holds them in a short command queue. Depends on brac_pkg.
`timescale 1ns / 1ps

module brac_front import brac_pkg::*; #(
  parameter int MAX_READ_RUN = MAX_READ_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_first_of_payload,
  input  logic              in_last_of_payload,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [RUN_W-1:0]  in_max_count,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_take
);

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);
  localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(MAX_READ_RUN);

  cmd_t          q_r [CQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  cmd_t          dec;
  logic          push_ok;
  logic          pop_ok;

  always_comb begin
    dec.data    = in_data_byte;
    dec.first   = in_first_of_payload;
    dec.last    = in_last_of_payload;
    dec.len     = in_payload_length;
    dec.run_max = (in_max_count > RUN_CAP) ? RUN_CAP : in_max_count;
    dec.op      = op_t'(in_operation);
    case (in_operation)
      OP_WRITE, OP_DONE, OP_READ: begin
        dec.legal = 1'b1;
      end
      default: begin
        dec.legal = 1'b0;
      end
    endcase
  end

  assign in_full   = (cnt_r == CW'(CQ_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- hdl/brac_back.sv -----
// Back end of the byte ring: ring store, counters, payload admission and the
// read sequencer, with one result stage in front of the result queue.
// Depends on brac_pkg.
`timescale 1ns / 1ps

module brac_back import brac_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [LEN_W-1:0] cfg_data,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  logic             oq_room,
  output res_t             res,
  output logic             res_valid
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [16:0] DEPTH_V = 17'(RING_DEPTH);
  localparam logic [LEN_W-1:0] CAP_RST = LEN_W'((RING_DEPTH < 1024) ? RING_DEPTH : 1024);

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] cap_r, cap_nxt;
  logic [LEN_W-1:0] rp_r, rp_nxt;
  logic [LEN_W-1:0] held_r, held_nxt;
  logic             done_r, done_nxt;
  logic             adm_r, adm_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] alen_r, alen_nxt;
  logic [RUN_W-1:0] left_r, left_nxt;
  logic             s1_v_r, s1_v_nxt;
  res_t             s1_r, s1_nxt;

  logic             mem_we;
  logic [LEN_W-1:0] mem_wa;
  logic             mem_re;
  logic [LEN_W-1:0] mem_ra;
  logic [LEN_W-1:0] rp_inc;

  always_comb begin
    logic             w_adm;
    logic [LEN_W-1:0] w_pos;
    logic [LEN_W-1:0] w_alen;
    logic [LEN_W-1:0] w_free;
    logic [LEN_W:0]   w_sum;
    logic [RUN_W-1:0] r_cnt;

    state_nxt = state_r;
    cap_nxt   = cap_r;
    rp_nxt    = rp_r;
    held_nxt  = held_r;
    done_nxt  = done_r;
    adm_nxt   = adm_r;
    pos_nxt   = pos_r;
    alen_nxt  = alen_r;
    left_nxt  = left_r;
    s1_v_nxt  = 1'b0;
    s1_nxt    = s1_r;
    cmd_take  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_re    = 1'b0;
    mem_ra    = rp_r;
    rp_inc    = rp_r + 1'b1;

    w_adm  = adm_r;
    w_pos  = pos_r;
    w_alen = alen_r;
    w_free = cap_r - held_r;
    w_sum  = '0;
    r_cnt  = (({{(LEN_W - RUN_W){1'b0}}, cmd.run_max}) > held_r) ?
             held_r[RUN_W-1:0] : cmd.run_max;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && oq_room) begin
          cmd_take      = 1'b1;
          s1_v_nxt      = 1'b1;
          s1_nxt.kind   = KIND_STATUS;
          s1_nxt.status = 1'b0;
          s1_nxt.rbyte  = '0;
          s1_nxt.last   = 1'b1;
          if (!cmd.legal) begin
            s1_nxt.status = 1'b1;
          end else begin
            case (cmd.op)
              OP_WRITE: begin
                if (cmd.first) begin
                  w_adm  = (cmd.len != '0) && !done_r && (cmd.len <= w_free);
                  w_pos  = '0;
                  w_alen = w_adm ? cmd.len : '0;
                end
                adm_nxt  = w_adm;
                pos_nxt  = w_pos;
                alen_nxt = w_alen;
                if (!w_adm) begin
                  s1_nxt.status = 1'b1;
                end else if (w_pos >= w_alen) begin
                  adm_nxt       = 1'b0;
                  s1_nxt.status = 1'b1;
                end else begin
                  w_sum = {1'b0, rp_r} + {1'b0, held_r} + {1'b0, w_pos};
                  if (w_sum >= {1'b0, cap_r}) begin
                    w_sum = w_sum - {1'b0, cap_r};
                  end
                  mem_we  = 1'b1;
                  mem_wa  = w_sum[LEN_W-1:0];
                  pos_nxt = w_pos + 1'b1;
                  if (cmd.last) begin
                    adm_nxt = 1'b0;
                    if ((w_pos + 1'b1) != w_alen) begin
                      s1_nxt.status = 1'b1;
                    end else begin
                      held_nxt = held_r + w_alen;
                    end
                  end
                end
              end
              OP_DONE: begin
                s1_nxt.status = done_r;
                done_nxt      = 1'b1;
              end
              OP_READ: begin
                if (r_cnt == '0) begin
                  s1_nxt.kind = KIND_EMPTY;
                end else begin
                  mem_re      = 1'b1;
                  rp_nxt      = (rp_inc == cap_r) ? '0 : rp_inc;
                  held_nxt    = held_r - 1'b1;
                  s1_nxt.kind = KIND_DATA;
                  s1_nxt.last = (r_cnt == RUN_W'(1));
                  left_nxt    = r_cnt - 1'b1;
                  if (r_cnt != RUN_W'(1)) begin
                    state_nxt = ST_RUN;
                  end
                end
              end
              default: begin
                s1_nxt.status = 1'b1;
              end
            endcase
          end
        end
      end
      ST_RUN: begin
        if (oq_room) begin
          mem_re        = 1'b1;
          rp_nxt        = (rp_inc == cap_r) ? '0 : rp_inc;
          held_nxt      = held_r - 1'b1;
          s1_v_nxt      = 1'b1;
          s1_nxt.kind   = KIND_DATA;
          s1_nxt.status = 1'b0;
          s1_nxt.rbyte  = '0;
          s1_nxt.last   = (left_r == RUN_W'(1));
          left_nxt      = left_r - 1'b1;
          if (left_r == RUN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    s1_nxt.held = held_nxt;
    s1_nxt.done = done_nxt;

    if (cfg_valid && (cfg_data != '0)) begin
      cap_nxt   = ({6'b0, cfg_data} > DEPTH_V) ? LEN_W'(RING_DEPTH) : cfg_data;
      rp_nxt    = '0;
      held_nxt  = '0;
      done_nxt  = 1'b0;
      adm_nxt   = 1'b0;
      pos_nxt   = '0;
      alen_nxt  = '0;
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= CAP_RST;
      rp_r    <= '0;
      held_r  <= '0;
      done_r  <= 1'b0;
      adm_r   <= 1'b0;
      pos_r   <= '0;
      alen_r  <= '0;
      left_r  <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      rp_r    <= rp_nxt;
      held_r  <= held_nxt;
      done_r  <= done_nxt;
      adm_r   <= adm_nxt;
      pos_r   <= pos_nxt;
      alen_r  <= alen_nxt;
      left_r  <= left_nxt;
      s1_v_r  <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(mem_wa)] <= cmd.data;
    end
    if (mem_re) begin
      rd_data_r <= mem[AW'(mem_ra)];
    end
  end

  always_comb begin
    res       = s1_r;
    res.rbyte = (s1_r.kind == KIND_DATA) ? rd_data_r : '0;
  end

  assign res_valid = s1_v_r;

endmodule

// ----- hdl/brac_out_q.sv -----
// Result queue of the byte ring: holds finished result items until popped
// and tells the back end whether another result may be started.
// Depends on brac_pkg.
`timescale 1ns / 1ps

module brac_out_q import brac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic room,
  input  logic pop,
  output logic empty,
  output res_t dout
);

  localparam int PW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int CW = $clog2(OQ_DEPTH + 1);

  res_t          q_r [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   fill;
  logic          pop_ok;

  assign empty  = (cnt_r == '0);
  assign pop_ok = pop && !empty;
  assign dout   = q_r[rd_ptr_r];
  assign fill   = {1'b0, cnt_r} + (CW + 1)'(push);
  assign room   = (fill < (CW + 1)'(OQ_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/brac_checker.sv -----
// Port-level checker of the byte ring, bound to the top level.
// Depends on brac_pkg and byte_ring_with_atomic_commit_defines.svh.
`timescale 1ns / 1ps
`include "byte_ring_with_atomic_commit_defines.svh"

module brac_checker import brac_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [1:0]        out_kind,
  input logic              out_status,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic              out_last_of_run,
  input logic [LEN_W-1:0]  out_bytes_held,
  input logic              out_done_flag
);

  `BRAC_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop,
    !out_empty && $stable(out_kind) && $stable(out_status) && $stable(out_read_byte) &&
    $stable(out_last_of_run) && $stable(out_bytes_held) && $stable(out_done_flag),
    "waiting result item changed while stalled")
  `BRAC_ASSERT_NOW(a_empty_after_reset, $past(!rst_n), out_empty,
    "result queue not empty after reset")
  `BRAC_ASSERT_NOW(a_read_status_clear,
    !out_empty && (out_kind == KIND_DATA || out_kind == KIND_EMPTY), !out_status,
    "read result item carries a reject status")
  `BRAC_ASSERT_NOW(a_empty_read_shape, !out_empty && out_kind == KIND_EMPTY,
    out_last_of_run && out_read_byte == '0, "empty read item is not a single zero result")

endmodule

bind byte_ring_with_atomic_commit brac_checker u_brac_checker (.*);

// ----- tb/tb_byte_ring_with_atomic_commit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for byte_ring_with_atomic_commit: a directed table, then random
// payload, read and done traffic over several capacities, checked against a local predictor.
// Depends on brac_pkg and the byte_ring_with_atomic_commit RTL only.

module tb_byte_ring_with_atomic_commit;
  import brac_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SHOWN_MAX = 10;
  localparam int SQUEEZE_CYCLES = 400;

  typedef struct {
    logic [1:0]        op;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [RUN_W-1:0]  run_max;
    bit                typed;
    res_t              want;
  } ring_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [1:0]        in_operation = 2'd0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_first_of_payload = 1'b0;
  logic              in_last_of_payload = 1'b0;
  logic [LEN_W-1:0]  in_payload_length = '0;
  logic [RUN_W-1:0]  in_max_count = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [1:0]        out_kind;
  logic              out_status;
  logic [BYTE_W-1:0] out_read_byte;
  logic              out_last_of_run;
  logic [LEN_W-1:0]  out_bytes_held;
  logic              out_done_flag;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;

  // predicted ring state
  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH_DEF];
  int                ring_cap = RING_DEPTH_DEF;
  int                ring_rd = 0;
  int                ring_held = 0;
  bit                ring_done = 1'b0;
  bit                pay_open = 1'b0;
  int                pay_pos = 0;
  int                pay_len = 0;

  res_t              ring_results_due[$];
  ring_item_t        directed_items[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  commits = 0;
  int  cfg_writes = 0;
  int  cycles = 0;
  bit  steady = 1'b0;
  bit  hold_off_req = 1'b0;

  byte_ring_with_atomic_commit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .in_first_of_payload (in_first_of_payload),
    .in_last_of_payload  (in_last_of_payload),
    .in_payload_length   (in_payload_length),
    .in_max_count        (in_max_count),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_kind            (out_kind),
    .out_status          (out_status),
    .out_read_byte       (out_read_byte),
    .out_last_of_run     (out_last_of_run),
    .out_bytes_held      (out_bytes_held),
    .out_done_flag       (out_done_flag),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               ring_results_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void note_result(kind_t kind, logic status, logic [BYTE_W-1:0] b,
                                      logic last);
    res_t r;
    r.kind   = kind;
    r.status = status;
    r.rbyte  = b;
    r.last   = last;
    r.held   = LEN_W'(ring_held);
    r.done   = ring_done;
    ring_results_due.push_back(r);
  endfunction

  function automatic void ring_advance(ring_item_t s);
    int   n;
    int   addr;
    logic st;
    case (s.op)
      OP_WRITE: begin
        if (s.first) begin
          pay_open = s.len != 0 && !ring_done && int'(s.len) <= ring_cap - ring_held;
          pay_pos  = 0;
          pay_len  = pay_open ? int'(s.len) : 0;
        end
        st = 1'b1;
        if (pay_open && pay_pos >= pay_len) begin
          pay_open = 1'b0;
        end else if (pay_open) begin
          addr = (ring_rd + ring_held + pay_pos) % ring_cap;
          ring_bytes[addr] = s.data;
          pay_pos++;
          st = 1'b0;
          if (s.last) begin
            pay_open = 1'b0;
            if (pay_pos != pay_len) begin
              st = 1'b1;
            end else begin
              ring_held += pay_len;
              commits++;
            end
          end
        end
        note_result(KIND_STATUS, st, '0, 1'b1);
      end
      OP_DONE: begin
        st = ring_done;
        ring_done = 1'b1;
        note_result(KIND_STATUS, st, '0, 1'b1);
      end
      OP_READ: begin
        n = ring_held;
        if (n > int'(s.run_max)) n = int'(s.run_max);
        if (n > MAX_READ_RUN_DEF) n = MAX_READ_RUN_DEF;
        if (n == 0) note_result(KIND_EMPTY, 1'b0, '0, 1'b1);
        for (int i = 0; i < n; i++) begin
          addr = ring_rd % ring_cap;
          ring_rd = (addr + 1) % ring_cap;
          ring_held--;
          note_result(KIND_DATA, 1'b0, ring_bytes[addr], i == n - 1);
        end
      end
      default: begin
        note_result(KIND_STATUS, 1'b1, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void ring_configure(int v);
    if (v == 0) return;
    ring_cap  = v > RING_DEPTH_DEF ? RING_DEPTH_DEF : v;
    ring_rd   = 0;
    ring_held = 0;
    ring_done = 1'b0;
    pay_open  = 1'b0;
    pay_pos   = 0;
    pay_len   = 0;
  endfunction

  function automatic ring_item_t mk(int op, int data, bit first, bit last, int len,
                                    int run_max);
    ring_item_t s;
    s.op      = 2'(op);
    s.data    = BYTE_W'(data);
    s.first   = first;
    s.last    = last;
    s.len     = LEN_W'(len);
    s.run_max = RUN_W'(run_max);
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic void add_row(int op, int data, bit first, bit last, int len, int run_max,
                                  bit typed, kind_t kind, bit status, int held, bit done);
    ring_item_t s;
    s = mk(op, data, first, last, len, run_max);
    s.typed       = typed;
    s.want.kind   = kind;
    s.want.status = status;
    s.want.rbyte  = '0;
    s.want.last   = 1'b1;
    s.want.held   = LEN_W'(held);
    s.want.done   = done;
    directed_items.push_back(s);
  endfunction

  task automatic offer(ring_item_t s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation        = s.op;
    in_data_byte        = s.data;
    in_first_of_payload = s.first;
    in_last_of_payload  = s.last;
    in_payload_length   = s.len;
    in_max_count        = s.run_max;
    in_push             = 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    items_sent++;
    ring_advance(s);
    if (s.typed) ring_results_due[ring_results_due.size() - 1] = s.want;
  endtask

  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = LEN_W'(v);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ring_configure(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_payload();
    int room;
    int len;
    int n;
    int shape;
    bit cut;
    room  = ring_cap - ring_held;
    shape = $urandom_range(0, 99);
    cut   = 1'b0;
    if (shape < 6) len = 0;
    else if (shape < 14) len = $urandom_range(room + 1, 2047);
    else if (room > 0) len = $urandom_range(1, room < 20 ? room : 20);
    else len = $urandom_range(1, 20);
    n = len;
    if (len == 0 || len > room) n = $urandom_range(1, 3);
    else if (shape >= 80 && shape < 90 && len > 1) n = $urandom_range(1, len - 1);
    else if (shape >= 90 && shape < 95) n = len + $urandom_range(1, 2);
    else if (shape >= 95 && len > 1) begin
      n   = $urandom_range(1, len - 1);
      cut = 1'b1;
    end
    for (int i = 1; i <= n; i++) begin
      offer(mk(OP_WRITE, $urandom_range(0, 255), i == 1, i == n && !cut,
               i == 1 ? len : $urandom_range(0, 2047), $urandom_range(0, 127)));
    end
  endtask

  task automatic run_phase(int cap_value, int n_items, int read_pct, bit quiet, bit squeeze);
    int target;
    int r;
    int run_max;
    write_capacity(cap_value);
    steady       = quiet;
    hold_off_req = squeeze;
    target       = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
        r = $urandom_range(0, 99);
        if (r < 20) run_max = 0;
        else if (r < 40) run_max = $urandom_range(64, 127);
        else run_max = $urandom_range(1, 63);
        offer(mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 2047), run_max));
      end else if (r < read_pct + 3) begin
        offer(mk(OP_DONE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 2047), $urandom_range(0, 127)));
      end else if (r < read_pct + 8) begin
        offer(mk(r[0] ? OP_SPARE : OP_WRITE, $urandom_range(0, 255), r[0],
                 $urandom_range(0, 1), $urandom_range(0, 2047), $urandom_range(0, 127)));
      end else begin
        random_payload();
      end
    end
    steady = 1'b0;
  endtask

  // receiver: random pop gaps, plus one long hold-off on request
  initial begin : pop_driver
    int idle_left;
    int stall_left;
    idle_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall_left   = SQUEEZE_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_pop = 1'b0;
      end else begin
        out_pop   = 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      results_seen++;
      if (ring_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected result: kind %0d status %0b byte %02h last %0b held %0d done %0b",
                   out_kind, out_status, out_read_byte, out_last_of_run, out_bytes_held,
                   out_done_flag);
      end else begin
        want = ring_results_due.pop_front();
        if (out_kind !== want.kind || out_status !== want.status ||
            out_read_byte !== want.rbyte || out_last_of_run !== want.last ||
            out_bytes_held !== want.held || out_done_flag !== want.done) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX) begin
            $display("result %0d: want kind %0d st %0b byte %02h last %0b held %0d done %0b",
                     results_seen, want.kind, want.status, want.rbyte, want.last, want.held,
                     want.done);
            $display("  got kind %0d st %0b byte %02h last %0b held %0d done %0b",
                     out_kind, out_status, out_read_byte, out_last_of_run, out_bytes_held,
                     out_done_flag);
          end
        end
      end
    end
  end

  initial begin
    add_row(OP_READ,  8'h00, 0, 0,    0,   0, 1, KIND_EMPTY,  0, 0, 0);
    add_row(OP_SPARE, 8'hFF, 1, 1, 2047, 127, 1, KIND_STATUS, 1, 0, 0);
    add_row(OP_WRITE, 8'h3C, 1, 0,    0,   0, 1, KIND_STATUS, 1, 0, 0);
    add_row(OP_WRITE, 8'h3C, 0, 0,    5,   0, 1, KIND_STATUS, 1, 0, 0);
    add_row(OP_WRITE, 8'h00, 1, 0,    3,   0, 1, KIND_STATUS, 0, 0, 0);
    add_row(OP_WRITE, 8'hFF, 0, 0,    0,   0, 1, KIND_STATUS, 0, 0, 0);
    add_row(OP_WRITE, 8'hA5, 0, 1,    0,   0, 1, KIND_STATUS, 0, 3, 0);
    add_row(OP_WRITE, 8'h01, 1, 1, 1024,   0, 1, KIND_STATUS, 1, 3, 0);
    add_row(OP_WRITE, 8'hFF, 1, 1, 2047, 127, 1, KIND_STATUS, 1, 3, 0);
    add_row(OP_READ,  8'h00, 0, 0,    0, 127, 0, KIND_DATA,   0, 0, 0);
    add_row(OP_WRITE, 8'h5A, 1, 1,    1,   0, 1, KIND_STATUS, 0, 1, 0);
    add_row(OP_WRITE, 8'h11, 1, 0,    4,   0, 1, KIND_STATUS, 0, 1, 0);
    add_row(OP_WRITE, 8'h22, 0, 1,    0,   0, 1, KIND_STATUS, 1, 1, 0);
    add_row(OP_WRITE, 8'h33, 0, 0,    0,   0, 1, KIND_STATUS, 1, 1, 0);
    add_row(OP_WRITE, 8'h44, 1, 0,    2,   0, 1, KIND_STATUS, 0, 1, 0);
    add_row(OP_WRITE, 8'h55, 0, 0,    0,   0, 1, KIND_STATUS, 0, 1, 0);
    add_row(OP_WRITE, 8'h66, 0, 1,    0,   0, 1, KIND_STATUS, 1, 1, 0);
    add_row(OP_WRITE, 8'h77, 1, 0,    3,   0, 0, KIND_STATUS, 0, 0, 0);
    add_row(OP_WRITE, 8'h88, 0, 0,    0,   0, 0, KIND_STATUS, 0, 0, 0);
    add_row(OP_WRITE, 8'h99, 1, 0,    2,   0, 0, KIND_STATUS, 0, 0, 0);
    add_row(OP_WRITE, 8'hAA, 0, 1,    0,   0, 1, KIND_STATUS, 0, 3, 0);
    add_row(OP_WRITE, 8'hBB, 1, 0,    2,   0, 0, KIND_STATUS, 0, 0, 0);
    add_row(OP_DONE,  8'h00, 0, 0,    0,   0, 1, KIND_STATUS, 0, 3, 1);
    add_row(OP_WRITE, 8'hCC, 0, 1,    0,   0, 1, KIND_STATUS, 0, 5, 1);
    add_row(OP_WRITE, 8'hDD, 1, 1,    1,   0, 1, KIND_STATUS, 1, 5, 1);
    add_row(OP_DONE,  8'h00, 0, 0,    0,   0, 1, KIND_STATUS, 1, 5, 1);
    add_row(OP_READ,  8'h00, 0, 0,    0,  64, 0, KIND_DATA,   0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_items[i]) offer(directed_items[i]);

    run_phase(1,    20, 30, 0, 0);
    run_phase(0,    10, 30, 0, 0);
    run_phase(2047, 30, 10, 0, 1);
    run_phase(16,   20, 30, 1, 0);
    run_phase(100,  30, 20, 0, 0);
    run_phase(1024, 20, 35, 0, 0);

    drain();
    repeat (10) @(posedge clk);

    $display("ran %0d items through %0d capacity writes: %0d payloads committed, %0d results",
             items_sent, cfg_writes, commits, results_seen);
    $display("mismatches: %0d, cycles: %0d", mismatches, cycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- byte_ring_with_atomic_commit.f -----
+incdir+hdl
hdl/brac_pkg.sv
hdl/brac_front.sv
hdl/brac_back.sv
hdl/brac_out_q.sv
hdl/byte_ring_with_atomic_commit.sv
hdl/brac_checker.sv
tb/tb_byte_ring_with_atomic_commit.sv
